// File: rtl/lsf_pkg.sv
// lsf_pkg: shared types, widths and codes of the learning switch forwarder
// used by lsf_cell, lsf_match and learning_switch_forwarder_core
package lsf_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 3;
    localparam int STAMP_W = 32;
    localparam int MASK_W  = 8;
    localparam int ACT_W   = 2;
    localparam int EV_W    = 2;

    // stream widths, fields packed from bit 0 and padded to bytes
    localparam int IN_BITS  = 2 * MAC_W + PORT_W + STAMP_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = MASK_W + ACT_W + EV_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // ports that exist on this switch
    localparam logic [MASK_W-1:0] PORT_MASK =
        (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << PORT_COUNT) - 1);

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // forwarding actions
    localparam logic [ACT_W-1:0] ACT_BROADCAST = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLOOD     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNICAST   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FILTER    = 2'd3;

    // table events
    localparam logic [EV_W-1:0] EV_REFRESH = 2'd0;
    localparam logic [EV_W-1:0] EV_APPEND  = 2'd1;
    localparam logic [EV_W-1:0] EV_REPLACE = 2'd2;

    // one table entry
    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // outcome of one pass over the table
    typedef struct packed {
        logic               src_hit;
        logic [IDX_W-1:0]   src_idx;
        logic               dst_hit;
        logic [IDX_W-1:0]   dst_idx;
        logic [PORT_W-1:0]  dst_port;
        logic [IDX_W-1:0]   best_idx;
    } t_scan_res;

    // enabled ports limited to the ports that exist
    function automatic logic [MASK_W-1:0] f_usable(input logic [MASK_W-1:0] mask);
        f_usable = mask & PORT_MASK;
    endfunction

endpackage

// File: rtl/lsf_cell.sv
// lsf_cell: one table entry of the rotating address table
// depends on lsf_pkg for the entry type
module lsf_cell import lsf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_next,
    input  logic   i_wr_en,
    input  t_entry i_wr_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // learn write wins, otherwise take the neighbor's entry on a shift
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/lsf_match.sv
// lsf_match: compare unit at the head of the cell chain, one entry per cycle while i_en is high
// tracks source hit, destination hit and oldest stamp; depends on lsf_pkg
module lsf_match import lsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic               i_valid,
    input  t_entry             i_entry,
    input  logic [MAC_W-1:0]   i_src,
    input  logic [MAC_W-1:0]   i_dst,
    input  logic [STAMP_W-1:0] i_now,
    output t_scan_res          o_res
);

    t_scan_res          r_res;
    logic [STAMP_W-1:0] r_best_stamp;

    t_scan_res          n_res;
    logic [STAMP_W-1:0] n_best_stamp;

    t_scan_res          w_prev;
    logic [STAMP_W-1:0] w_prev_stamp;
    logic               w_first;

    assign w_first = (i_idx == '0);

    // step zero starts from a clean slate
    always_comb begin
        w_prev       = r_res;
        w_prev_stamp = r_best_stamp;
        if (w_first) begin
            w_prev       = '0;
            w_prev_stamp = i_now;
        end
    end

    // first match wins, strictly smaller stamp wins
    always_comb begin
        n_res        = w_prev;
        n_best_stamp = w_prev_stamp;
        if (i_valid && !w_prev.src_hit && (i_entry.mac == i_src)) begin
            n_res.src_hit = 1'b1;
            n_res.src_idx = i_idx;
        end
        if (i_valid && !w_prev.dst_hit && (i_entry.mac == i_dst)) begin
            n_res.dst_hit  = 1'b1;
            n_res.dst_idx  = i_idx;
            n_res.dst_port = i_entry.port;
        end
        if (i_valid && (i_entry.stamp < w_prev_stamp)) begin
            n_best_stamp   = i_entry.stamp;
            n_res.best_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res        <= n_res;
            r_best_stamp <= n_best_stamp;
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/learning_switch_forwarder_core.sv
// learning_switch_forwarder_core: learning bridge address table and forwarding decision
// depends on lsf_pkg, lsf_cell and lsf_match
//
// Usage:
//   s_axis carries one frame header per item (src_mac, dst_mac, ingress_port,
//   arrival stamp). m_axis returns one result item per header (egress_mask,
//   action, table_event). i_cfg_wr_en/i_cfg_wr_data write port_enable_mask.
//   The table is a ring of TABLE_ENTRIES cells that rotates one place per
//   cycle in S_SCAN past a single compare unit, so each header takes one full turn.
// Sequencing and throughput:
//   s_axis_tready is high only while idle. After an item is accepted the ring
//   turns once through S_SCAN, then S_FIN learns the source and builds the
//   result into the output register that drives m_axis_tvalid. S_FIN waits while
//   an older result is still held; a new item is taken only once back in idle.
// Reset:
//   i_rst_n (synchronous, active low) empties the table (entry count zero),
//   clears port_enable_mask and drops m_axis_tvalid. No clearing pass.
// Stall:
//   a waiting result sits in the output register; the next item is accepted
//   and scanned meanwhile, and its result waits until the output is taken.
module learning_switch_forwarder_core import lsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [MASK_W-1:0] i_cfg_wr_data,  // port_enable_mask
    // header items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // src_mac, dst_mac, ingress_port, arrival_time
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // egress_mask, action, table_event
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_step;
    logic [CNT_W-1:0]   r_count;
    logic [MASK_W-1:0]  r_port_en;

    // held header
    logic [MAC_W-1:0]   r_src;
    logic [MAC_W-1:0]   r_dst;
    logic [PORT_W-1:0]  r_ingress;
    logic [STAMP_W-1:0] r_now;

    // output register
    logic               r_m_valid;
    logic [MASK_W-1:0]  r_m_egress;
    logic [ACT_W-1:0]   r_m_action;
    logic [EV_W-1:0]    r_m_event;

    logic               w_in_acc;
    logic               w_scan;
    logic               w_fin_go;
    t_entry             w_entry [TABLE_ENTRIES];
    t_entry             w_wr_entry;
    t_scan_res          w_res;
    logic               w_step_valid;

    logic [EV_W-1:0]    n_event;
    logic [IDX_W-1:0]   n_wr_idx;
    logic [ACT_W-1:0]   n_action;
    logic [MASK_W-1:0]  n_egress;
    logic               w_dst_found;
    logic [PORT_W-1:0]  w_dst_port;
    logic [MASK_W-1:0]  w_usable;
    logic [MASK_W-1:0]  w_flood;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_scan        = (r_state == S_SCAN);
    assign w_fin_go      = (r_state == S_FIN) && (!r_m_valid || m_axis_tready);
    assign w_step_valid  = (CNT_W'(r_step) < r_count);

    // control state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_SCAN;
            S_SCAN:  if (r_step == IDX_W'(TABLE_ENTRIES - 1)) n_state = S_FIN;
            S_FIN:   if (w_fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_count   <= '0;
            r_port_en <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_step <= '0;
            end else if (w_scan) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_port_en <= i_cfg_wr_data;
            end
            if (w_fin_go && (n_event == EV_APPEND)) begin
                r_count <= r_count + 1'b1;
            end
            if (w_fin_go) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // header capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_src     <= s_axis_tdata[MAC_W-1:0];
            r_dst     <= s_axis_tdata[2*MAC_W-1:MAC_W];
            r_ingress <= s_axis_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
            r_now     <= s_axis_tdata[IN_BITS-1:2*MAC_W+PORT_W];
        end
    end

    // rotating ring of entries, head at cell zero
    assign w_wr_entry = '{mac: r_src, port: r_ingress, stamp: r_now};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        lsf_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_scan),
            .i_next     (w_entry[(g + 1) % TABLE_ENTRIES]),
            .i_wr_en    (w_fin_go && (n_wr_idx == IDX_W'(g))),
            .i_wr_entry (w_wr_entry),
            .o_entry    (w_entry[g])
        );
    end

    // compare unit watching the head cell
    lsf_match u_match (
        .i_clk   (i_clk),
        .i_en    (w_scan),
        .i_idx   (r_step),
        .i_valid (w_step_valid),
        .i_entry (w_entry[0]),
        .i_src   (r_src),
        .i_dst   (r_dst),
        .i_now   (r_now),
        .o_res   (w_res)
    );

    // learning decision
    always_comb begin
        if (w_res.src_hit) begin
            n_event  = EV_REFRESH;
            n_wr_idx = w_res.src_idx;
        end else if (r_count < CNT_W'(TABLE_ENTRIES)) begin
            n_event  = EV_APPEND;
            n_wr_idx = r_count[IDX_W-1:0];
        end else begin
            n_event  = EV_REPLACE;
            n_wr_idx = w_res.best_idx;
        end
    end

    // lookup as seen after learning: own source is known, an evicted entry is gone
    always_comb begin
        if (r_dst == r_src) begin
            w_dst_found = 1'b1;
            w_dst_port  = r_ingress;
        end else begin
            w_dst_found = w_res.dst_hit &&
                          !((n_event == EV_REPLACE) && (w_res.dst_idx == w_res.best_idx));
            w_dst_port  = w_res.dst_port;
        end
    end

    // forwarding decision
    assign w_usable = f_usable(r_port_en);
    assign w_flood  = w_usable & ~(MASK_W'(1) << r_ingress);

    always_comb begin
        if (r_dst == MAC_BCAST) begin
            n_action = ACT_BROADCAST;
            n_egress = w_flood;
        end else if (!w_dst_found) begin
            n_action = ACT_FLOOD;
            n_egress = w_flood;
        end else if (w_dst_port == r_ingress) begin
            n_action = ACT_FILTER;
            n_egress = '0;
        end else begin
            n_action = ACT_UNICAST;
            n_egress = (MASK_W'(1) << w_dst_port) & w_usable;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_m_egress <= n_egress;
            r_m_action <= n_action;
            r_m_event  <= n_event;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, r_m_event, r_m_action, r_m_egress};

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + 1'b1) && ($past(n_event) == EV_APPEND)))
        else $error("entry count moved without an append");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (w_scan && (r_step == '0)))
        else $error("accepted item did not start a scan at entry zero");

    a_filter_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_action == ACT_FILTER)) |-> (r_m_egress == '0))
        else $error("filtered item sent to a port");

endmodule
